// ===== src/earliest_free_room_allocator_core_defines.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the earliest-free room allocator
// concurrent checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_ROOM_ALLOCATOR_CORE_DEFINES_SVH
`define EARLIEST_FREE_ROOM_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define EFRA_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define EFRA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define EFRA_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define EFRA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== src/efra_pkg.sv =====
// ----------------------------------------------------------------------------
// efra_pkg
// shared constants and types of the earliest-free room allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efra_pkg;

	localparam int ROOMS   = 16;
	localparam int ROOM_W  = (ROOMS > 1) ? $clog2(ROOMS) : 1;
	localparam int CFG_W   = 5;
	localparam int TIME_W  = 32;
	localparam int END_W   = 48;
	localparam int CNT_W   = 32;
	localparam int DISP_W  = 4;
	localparam int IN_TDATA_W  = 2 * TIME_W;
	localparam int OUT_TDATA_W = DISP_W + END_W + DISP_W + CNT_W;

	typedef struct packed {
		logic              en;
		logic [ROOM_W-1:0] addr;
	} store_rd_t;

	typedef struct packed {
		logic              en;
		logic [ROOM_W-1:0] addr;
		logic [END_W-1:0]  room_end;
		logic [CNT_W-1:0]  bookings;
	} store_wr_t;

	typedef struct packed {
		logic [END_W-1:0] room_end;
		logic [CNT_W-1:0] bookings;
	} store_data_t;

endpackage

`default_nettype wire

// ===== src/efra_room_store.sv =====
// ----------------------------------------------------------------------------
// efra_room_store
// per-room end time and booking count memories, one read and one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efra_room_store (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 clear,
	input  wire efra_pkg::store_rd_t  rd,
	input  wire efra_pkg::store_wr_t  wr,
	output efra_pkg::store_data_t     rd_data
);
	import efra_pkg::*;

	logic [END_W-1:0] end_mem [ROOMS];
	logic [CNT_W-1:0] cnt_mem [ROOMS];
	logic [ROOMS-1:0] valid_q;

	logic [END_W-1:0] end_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             vld_s1;

	// entries not written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			end_mem[wr.addr] <= wr.room_end;
			cnt_mem[wr.addr] <= wr.bookings;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			end_s1 <= end_mem[rd.addr];
			cnt_s1 <= cnt_mem[rd.addr];
			vld_s1 <= valid_q[rd.addr];
		end
	end

	assign rd_data.room_end = vld_s1 ? end_s1 : '0;
	assign rd_data.bookings = vld_s1 ? cnt_s1 : '0;

endmodule

`default_nettype wire

// ===== src/earliest_free_room_allocator_core.sv =====
// ----------------------------------------------------------------------------
// earliest_free_room_allocator_core
// books each meeting into the lowest free room or the earliest-ending room
// ----------------------------------------------------------------------------
//  channel  | signals                   | direction | contents
//  ---------+---------------------------+-----------+---------------------------
//  s_       | tvalid tready tdata tuser | in        | one meeting per transfer
//  m_       | tvalid tready tdata       | out       | one booking per transfer
//  cfg_     | valid ready data          | in        | rooms_in_use register
//
//  a meeting is taken only in idle, then passes scan, drain, book and write-back
//  before the next one is taken; the room memory is read one room per cycle
//  during the scan, then once more for the count
//  reset clears the control state, the valid bits and the busiest-room record
//  a result waiting on m_tready stalls the write-back of the next meeting,
//  while the next meeting itself is still taken and scanned
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "earliest_free_room_allocator_core_defines.svh"

module earliest_free_room_allocator_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// meeting in
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [efra_pkg::IN_TDATA_W-1:0]     s_tdata,  // start_time, end_time
	input  wire logic [0:0]                          s_tuser,  // first_of_set
	// booking out
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// assigned_room, finish_time, busiest_room, busiest_count
	output logic [efra_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// configuration
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [efra_pkg::CFG_W-1:0]          cfg_data  // rooms_in_use
);
	import efra_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_BOOK  = 5'b01000,
		ST_WB    = 5'b10000
	} state_t;

	state_t state_q;

	// configuration register
	logic [CFG_W-1:0] rooms_q;

	// meeting held for the duration of its scan
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] dur_q;
	logic [ROOM_W-1:0] last_q;
	logic [ROOM_W-1:0] iss_q;

	// scan results
	logic              found_q;
	logic [ROOM_W-1:0] free_room_q;
	logic [ROOM_W-1:0] min_room_q;
	logic [END_W-1:0]  min_end_q;

	// chosen room and its finish
	logic [ROOM_W-1:0] room_q;
	logic [END_W-1:0]  finish_q;

	// read data tags
	logic              eval_vld_s1;
	logic [ROOM_W-1:0] eval_addr_s1;

	// running busiest room
	logic [ROOM_W-1:0] best_room_q;
	logic [CNT_W-1:0]  best_cnt_q;

	logic [OUT_TDATA_W-1:0] out_data_q;

	store_rd_t   st_rd;
	store_wr_t   st_wr;
	store_data_t st_data;

	logic              in_xfer;
	logic              in_first;
	logic [TIME_W-1:0] in_start;
	logic [TIME_W-1:0] in_stop;
	logic [TIME_W-1:0] in_dur;
	logic [ROOM_W-1:0] in_last;
	logic              hit;
	logic              less;
	logic [ROOM_W-1:0] chosen;
	logic [END_W:0]    delayed_sum;
	logic [END_W-1:0]  finish_nxt;
	logic              slot_free;
	logic              wb_fire;
	logic [CNT_W-1:0]  new_cnt;
	logic              take_best;
	logic [ROOM_W-1:0] best_room_nxt;
	logic [CNT_W-1:0]  best_cnt_nxt;

	// input decode
	assign in_xfer  = s_tvalid & s_tready;
	assign in_first = s_tuser[0];
	assign in_start = s_tdata[TIME_W-1:0];
	assign in_stop  = s_tdata[2*TIME_W-1:TIME_W];
	assign in_dur   = (in_stop > in_start) ? (in_stop - in_start) : '0;

	// clamp the room count to 1..ROOMS, kept as the index of the last room
	always_comb begin
		if (rooms_q == '0) begin
			in_last = '0;
		end else if (int'(rooms_q) >= ROOMS) begin
			in_last = ROOM_W'(ROOMS - 1);
		end else begin
			in_last = ROOM_W'(rooms_q - CFG_W'(1));
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rooms_q <= CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			rooms_q <= cfg_data;
		end
	end

	// one memory read per room during the scan, then one for the chosen count
	assign chosen    = found_q ? free_room_q : min_room_q;
	assign st_rd.en   = (state_q == ST_SCAN) || (state_q == ST_BOOK);
	assign st_rd.addr = (state_q == ST_SCAN) ? iss_q : chosen;

	efra_room_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (in_xfer & in_first),
		.rd      (st_rd),
		.wr      (st_wr),
		.rd_data (st_data)
	);

	// compare of one room's end time against the start and the running minimum
	assign hit  = (st_data.room_end <= {{(END_W-TIME_W){1'b0}}, start_q});
	assign less = (st_data.room_end < min_end_q);

	// delayed meeting keeps its duration, saturating at the end-time ceiling
	assign delayed_sum = {1'b0, min_end_q} + {{(END_W+1-TIME_W){1'b0}}, dur_q};
	always_comb begin
		if (found_q) begin
			finish_nxt = {{(END_W-TIME_W){1'b0}}, start_q}
				+ {{(END_W-TIME_W){1'b0}}, dur_q};
		end else if (delayed_sum[END_W]) begin
			finish_nxt = '1;
		end else begin
			finish_nxt = delayed_sum[END_W-1:0];
		end
	end

	// write-back waits until the output register can take the booking
	assign slot_free = !m_tvalid || m_tready;
	assign wb_fire   = (state_q == ST_WB) && slot_free;
	assign new_cnt   = (st_data.bookings == '1) ? st_data.bookings
		: st_data.bookings + CNT_W'(1);
	assign take_best = (new_cnt > best_cnt_q)
		|| ((new_cnt == best_cnt_q) && (room_q < best_room_q));
	assign best_room_nxt = take_best ? room_q : best_room_q;
	assign best_cnt_nxt  = take_best ? new_cnt : best_cnt_q;

	assign st_wr.en       = wb_fire;
	assign st_wr.addr     = room_q;
	assign st_wr.room_end = finish_q;
	assign st_wr.bookings = new_cnt;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eval_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			best_room_q <= '0;
			best_cnt_q  <= '0;
		end else begin
			eval_vld_s1 <= (state_q == ST_SCAN);

			// scan evaluation, one room per cycle
			if (eval_vld_s1 && !found_q && hit) begin
				found_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						found_q <= 1'b0;
						state_q <= ST_SCAN;
						if (in_first) begin
							best_room_q <= '0;
							best_cnt_q  <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (iss_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_BOOK;
				end
				ST_BOOK: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_fire) begin
						best_room_q <= best_room_nxt;
						best_cnt_q  <= best_cnt_nxt;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		eval_addr_s1 <= iss_q;

		if (in_xfer) begin
			start_q <= in_start;
			dur_q   <= in_dur;
			last_q  <= in_last;
			iss_q   <= '0;
		end else if ((state_q == ST_SCAN) && (iss_q != last_q)) begin
			iss_q <= iss_q + ROOM_W'(1);
		end

		if (eval_vld_s1) begin
			if (!found_q && hit) begin
				free_room_q <= eval_addr_s1;
			end
			// room zero seeds the minimum, later rooms win only when strictly earlier
			if ((eval_addr_s1 == '0) || less) begin
				min_room_q <= eval_addr_s1;
				min_end_q  <= st_data.room_end;
			end
		end

		if (state_q == ST_BOOK) begin
			room_q   <= chosen;
			finish_q <= finish_nxt;
		end

		if (wb_fire) begin
			out_data_q <= {best_cnt_nxt, DISP_W'(best_room_nxt), finish_q, DISP_W'(room_q)};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (wb_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign m_tdata = out_data_q;

	// a taken meeting always starts its scan
	`EFRA_ASSERT_NEXT(a_accept_scans, clk, arst_n, in_xfer, state_q == ST_SCAN)
	// the room memory is never written while a booking is stuck in the output
	`EFRA_ASSERT_NOW(a_wb_slot_free, clk, arst_n, st_wr.en, !m_tvalid || m_tready)
	// the chosen room lies within the clamped room count
	`EFRA_ASSERT_NOW(a_wb_in_range, clk, arst_n, st_wr.en, room_q <= last_q)
	// scan reads never run past the last room
	`EFRA_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == ST_SCAN, iss_q <= last_q)

endmodule

`default_nettype wire

// ===== dv/tb_earliest_free_room_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_earliest_free_room_allocator_core
// self-checking bench: streams meetings in, predicts each booking from its
// own room ledger and compares every booking transfer field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_earliest_free_room_allocator_core;

	import efra_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 62;
	localparam int LONG_ITEMS  = 6;
	localparam logic [END_W-1:0] END_SAT = '1;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	typedef struct packed {
		logic [CNT_W-1:0]  busiest_count;
		logic [DISP_W-1:0] busiest;
		logic [END_W-1:0]  finish;
		logic [DISP_W-1:0] room;
	} booking_t;

	// room ledger: mirrors the allocator state and queues the bookings it owes
	class booking_ledger;
		logic [END_W-1:0]  room_end [ROOMS];
		logic [CNT_W-1:0]  room_count [ROOMS];
		int                top_room;
		logic [CNT_W-1:0]  top_count;
		logic [CFG_W-1:0]  rooms_reg;
		booking_t          owed_bookings [$];
		int                errors;

		function new();
			clear_rooms();
			rooms_reg = 5'd16;
			errors = 0;
		endfunction

		function void clear_rooms();
			for (int i = 0; i < ROOMS; i++) begin
				room_end[i] = '0;
				room_count[i] = '0;
			end
			top_room = 0;
			top_count = '0;
		endfunction

		function void set_rooms(logic [CFG_W-1:0] v);
			rooms_reg = v;
		endfunction

		function int pending();
			return owed_bookings.size();
		endfunction

		function void note_meeting(logic first, logic [TIME_W-1:0] st,
			logic [TIME_W-1:0] en);
			int          n;
			int          room;
			bit          found;
			logic [TIME_W-1:0] dur;
			logic [END_W:0]    fin;
			booking_t    b;
			n = rooms_reg;
			if (n < 1) n = 1;
			if (n > ROOMS) n = ROOMS;
			dur = (en > st) ? en - st : '0;
			if (first) clear_rooms();
			found = 1'b0;
			room = 0;
			for (int i = 0; i < n; i++) begin
				if (!found && room_end[i] <= END_W'(st)) begin
					room = i;
					found = 1'b1;
				end
			end
			if (found) begin
				fin = (END_W+1)'(st) + (END_W+1)'(dur);
			end else begin
				// nothing free: earliest-ending room, meeting slides back
				room = 0;
				for (int i = 1; i < n; i++)
					if (room_end[i] < room_end[room]) room = i;
				fin = (END_W+1)'(room_end[room]) + (END_W+1)'(dur);
				if (fin > (END_W+1)'(END_SAT)) fin = (END_W+1)'(END_SAT);
			end
			room_end[room] = fin[END_W-1:0];
			if (room_count[room] != CNT_SAT) room_count[room]++;
			if (room_count[room] > top_count ||
				(room_count[room] == top_count && room < top_room)) begin
				top_count = room_count[room];
				top_room = room;
			end
			b.room = room[DISP_W-1:0];
			b.finish = fin[END_W-1:0];
			b.busiest = top_room[DISP_W-1:0];
			b.busiest_count = top_count;
			owed_bookings.push_back(b);
		endfunction

		function void check_booking(logic [OUT_TDATA_W-1:0] data);
			booking_t got;
			booking_t exp_b;
			got = booking_t'(data);
			if (owed_bookings.size() == 0) begin
				$error("booking with none expected: room %0d finish %0d",
					got.room, got.finish);
				errors++;
				return;
			end
			exp_b = owed_bookings.pop_front();
			if (got.room !== exp_b.room) begin
				$error("assigned_room: expected %0d, got %0d", exp_b.room, got.room);
				errors++;
			end
			if (got.finish !== exp_b.finish) begin
				$error("finish_time: expected %0d, got %0d", exp_b.finish, got.finish);
				errors++;
			end
			if (got.busiest !== exp_b.busiest) begin
				$error("busiest_room: expected %0d, got %0d",
					exp_b.busiest, got.busiest);
				errors++;
			end
			if (got.busiest_count !== exp_b.busiest_count) begin
				$error("busiest_count: expected %0d, got %0d",
					exp_b.busiest_count, got.busiest_count);
				errors++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;   // start_time, end_time
	logic [0:0]              s_tuser;   // first_of_set
	logic                    m_tvalid;
	logic                    m_tready;
	// assigned_room, finish_time, busiest_room, busiest_count
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_data;  // rooms_in_use

	booking_ledger board;
	int            send_idle_pct;
	int            recv_stall_pct;
	bit            pressure_req;
	int            hold_left;
	int            cycles;
	logic [TIME_W-1:0] slot_clock;

	earliest_free_room_allocator_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (pressure_req) begin
				pressure_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_booking(m_tdata);
	end

	task automatic send_meeting(input logic first, input logic [TIME_W-1:0] st,
		input logic [TIME_W-1:0] en);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {en, st};
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_meeting(first, st, en);
	endtask

	// drop valid and let every owed booking come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_rooms(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_rooms(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
			default: begin send_idle_pct = 23; recv_stall_pct = 23; end
		endcase
	endtask

	// mostly ordered sets of overlapping meetings, some noise in between
	task automatic random_meetings(input int count);
		int                roll;
		logic              first;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] en;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			first = 1'b0;
			if (k == 0 || roll < 6) begin
				slot_clock = (roll < 3) ? $urandom : $urandom_range(0, 1000);
				first = (k == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
			end
			if (roll >= 6 && roll < 14) begin
				st = $urandom;
				en = $urandom;
				first = ($urandom_range(0, 9) == 0);
			end else begin
				slot_clock = slot_clock + $urandom_range(0, 40);
				st = slot_clock;
				case ($urandom_range(0, 9))
					0: en = st;
					1: en = $urandom;
					default: en = st + $urandom_range(1, 300);
				endcase
			end
			send_meeting(first, st, en);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] phase_rooms [PHASES];
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		pressure_req = 1'b0;
		slot_clock = '0;
		set_idling(0);
		phase_rooms = '{5'd31, 5'd0, 5'd17, 5'd2, 5'd16, 5'd1, 5'd8, 5'd12};
		phase_rooms[6] = $urandom_range(1, 16);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset room count of sixteen
		send_meeting(1'b1, 32'd0, 32'd0);
		send_meeting(1'b0, 32'd0, 32'hFFFF_FFFF);
		send_meeting(1'b0, 32'd0, 32'd10);
		send_meeting(1'b0, 32'd5, 32'd5);
		send_meeting(1'b0, 32'd5, 32'd3);
		for (int i = 0; i < 14; i++) send_meeting(1'b0, 32'd20, 32'd50);
		send_meeting(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_meeting(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_meeting(1'b0, 32'd7, 32'd8);
		send_meeting(1'b1, 32'hFFFF_FFFF, 32'd0);
		send_meeting(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
		drain();

		// one room, back-to-back full-length meetings pile up long delays
		write_rooms(5'd1);
		send_meeting(1'b1, 32'd0, 32'hFFFF_FFFF);
		for (int i = 1; i < LONG_ITEMS; i++) send_meeting(1'b0, 32'd0, 32'hFFFF_FFFF);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_rooms(phase_rooms[p]);
			set_idling(p % 4);
			// long receiver hold-off so the block backs up into its input
			if (p == 0) pressure_req = 1'b1;
			random_meetings(PHASE_ITEMS);
			drain();
		end

		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
